### design/cfcg_pkg.sv
// ----------------------------------------------------------------------------
// cfcg_pkg
// Shared widths, register indexes and the quarter-sine gain table for the
// crossfading channel gate.
// ----------------------------------------------------------------------------
package cfcg_pkg;

    // field widths
    localparam int CH_W     = 9;
    localparam int SAMPLE_W = 24;
    localparam int FADE_W   = 24;
    localparam int COUNT_W  = FADE_W + 1;
    localparam int GAIN_W   = 17;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

    // stream word widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_SAMPLES = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CHANNELS = 1'd1;

    // reset values
    localparam logic [FADE_W-1:0] FADE_SAMPLES_RST = 24'd2400;
    localparam logic [CH_W-1:0]   NUM_CHANNELS_RST = 9'd2;

    localparam logic [CH_W-1:0] MAX_CHANNELS = 9'd256;

    // gain table: GAIN_TABLE_SIZE+1 entries, index width holds the top entry
    localparam int GAIN_TABLE_SIZE = 1024;
    localparam int IDX_W           = 11;
    localparam logic [IDX_W-1:0] IDX_FULL = 11'd1024;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q16     = 64'd65536;

    typedef logic [GAIN_TABLE_SIZE:0][GAIN_W-1:0] gain_tab_t;

    // sin(pi/2*k/size) in q1.16 by a fixed q30 taylor series, evaluated at elaboration
    function automatic gain_tab_t build_gain_tab();
        gain_tab_t         tab;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic [63:0]       g;
        logic signed [63:0] sum;
        int                k;
        int                n;
        tab = '0;
        for (k = 0; k <= GAIN_TABLE_SIZE; k++) begin
            x    = (HALF_PI_Q30 * 64'(k) + 64'(GAIN_TABLE_SIZE / 2)) / GAIN_TABLE_SIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (n = 1; n <= 6; n++) begin
                term = (term * x2) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    default: term = term / 156;
                endcase
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            g = ($unsigned(sum) + 64'd8192) >> 14;
            if (g > ONE_Q16) begin
                g = ONE_Q16;
            end
            tab[k] = g[GAIN_W-1:0];
        end
        return tab;
    endfunction

endpackage

### design/crossfading_channel_gate_unit.sv
// ----------------------------------------------------------------------------
// crossfading_channel_gate_unit
// Equal-power crossfade switch: routes each sample to a selected channel and
// crossfades between the old and the new channel over a programmable length.
// ----------------------------------------------------------------------------
// Usage
//   s_ side takes one word per audio sample: channel select and sample.
//   m_ side gives one word per sample: the channel fading in (or carrying
//   full signal) with its value, and the channel fading out with its value.
//   Channels not named carry zero.
//   cfg_ port writes fade_samples (index 0) and num_channels (index 1); write
//   only while no sample is in flight. Writing fade_samples jumps to the fade's end.
// Timing
//   A word taken while a fade is in progress and the fade length is non-zero
//   passes through the restoring divider that turns the fade position into a
//   table index, then two table reads, two passes through one 24x18
//   multiplier and the output load. Otherwise the divider is skipped.
//   s_tready is low meanwhile, so no new word is taken until the result of
//   the last one is loaded into the output register.
// Reset and stall
//   aresetn clears the channel state and fade count and reloads the register
//   defaults. A result waits in the output register; the next word may be
//   accepted meanwhile, but its result holds until m_tready takes the first.
// ----------------------------------------------------------------------------
module crossfading_channel_gate_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: channel_select[8:0], sample_in[32:9], zero pad
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cfcg_pkg::S_DATA_W-1:0]        s_tdata,
    // m_tdata: new_channel[8:0], new_value[32:9], old_channel[41:33],
    //          old_value[65:42], zero pad
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cfcg_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [cfcg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cfcg_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import cfcg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RDS  = 3'd2;
    localparam logic [2:0] S_RDC  = 3'd3;
    localparam logic [2:0] S_MLC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam gain_tab_t GAIN_TAB = build_gain_tab();
    localparam int DVD_W = FADE_W + IDX_W;

    // control state
    logic [2:0]                state_reg, state_next;
    logic [FADE_W-1:0]         fade_samples_reg, fade_samples_next;
    logic [CH_W-1:0]           num_channels_reg, num_channels_next;
    logic [CH_W-1:0]           cur_ch_reg, cur_ch_next;
    logic [CH_W-1:0]           prev_ch_reg, prev_ch_next;
    logic signed [COUNT_W-1:0] fade_count_reg, fade_count_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // datapath
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       fading_reg, fading_next;
    logic [FADE_W-1:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]           dvd_reg, dvd_next;
    logic [IDX_W-1:0]           quot_reg, quot_next;
    logic [GAIN_W-1:0]          rom_q_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [SAMPLE_W-1:0]        nv_reg, nv_next;
    logic [M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    // accept-time decode
    logic [CH_W-1:0]           sel;
    logic [CH_W-1:0]           limit;
    logic                      switch_ch;
    logic [CH_W-1:0]           cur_a;
    logic [CH_W-1:0]           prev_a;
    logic signed [COUNT_W-1:0] fc_a;
    logic                      fading_a;
    logic [FADE_W-1:0]         num_a;
    logic [DVD_W-1:0]          dvd_a;

    // divider step, table address and rounding
    logic [FADE_W:0]            div_t;
    logic                       div_ge;
    logic [IDX_W-1:0]           idx_eff;
    logic [IDX_W-1:0]           rom_addr;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic [SAMPLE_W-1:0]        scaled;
    logic [SAMPLE_W-1:0]        out_nv;
    logic [CH_W-1:0]            out_oc;
    logic [SAMPLE_W-1:0]        out_ov;
    logic                       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // channel switch decision and fade position for an arriving word
    always_comb begin
        sel       = s_tdata[CH_W-1:0];
        limit     = (num_channels_reg > MAX_CHANNELS) ? MAX_CHANNELS : num_channels_reg;
        switch_ch = (sel != cur_ch_reg) && (sel <= limit);
        cur_a     = switch_ch ? sel : cur_ch_reg;
        prev_a    = switch_ch ? cur_ch_reg : prev_ch_reg;
        fc_a      = switch_ch ? $signed({1'b0, fade_samples_reg}) : fade_count_reg;
        fading_a  = !fc_a[COUNT_W-1];
        num_a     = (fc_a[FADE_W-1:0] > fade_samples_reg) ? '0
                                                          : fade_samples_reg - fc_a[FADE_W-1:0];
        dvd_a     = {num_a, {(IDX_W-1){1'b0}}} + DVD_W'(fade_samples_reg >> 1);
    end

    // one restoring divide step
    always_comb begin
        div_t  = {rem_reg, dvd_reg[IDX_W-1]};
        div_ge = (div_t >= {1'b0, fade_samples_reg});
    end

    // table address: sine gain first, cosine gain second
    always_comb begin
        idx_eff = (quot_reg > IDX_FULL) ? IDX_FULL : quot_reg;
        case (state_reg)
            S_RDC:   rom_addr = IDX_FULL - idx_eff;
            default: rom_addr = idx_eff;
        endcase
    end

    // round to nearest, halves up
    always_comb begin
        prod_rnd = prod_reg + PROD_W'(32768);
        scaled   = prod_rnd[SAMPLE_W+15:16];
    end

    // result fields
    always_comb begin
        out_nv = (cur_ch_reg != '0) ? (fading_reg ? nv_reg : sample_reg) : '0;
        out_oc = ((prev_ch_reg != '0) && fading_reg) ? prev_ch_reg : '0;
        out_ov = ((prev_ch_reg != '0) && fading_reg) ? scaled : '0;
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        fade_samples_next = fade_samples_reg;
        num_channels_next = num_channels_reg;
        cur_ch_next       = cur_ch_reg;
        prev_ch_next      = prev_ch_reg;
        fade_count_next   = fade_count_reg;
        cnt_next          = cnt_reg;
        m_tvalid_next     = m_tvalid_reg;
        sample_next       = sample_reg;
        fading_next       = fading_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        quot_next         = quot_reg;
        prod_next         = prod_reg;
        nv_next           = nv_reg;
        m_tdata_next      = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sample_next  = $signed(s_tdata[CH_W+SAMPLE_W-1:CH_W]);
                    cur_ch_next  = cur_a;
                    prev_ch_next = prev_a;
                    fading_next  = fading_a;
                    if (fading_a && ((cur_a != '0) || (prev_a != '0))) begin
                        fade_count_next = fc_a - COUNT_W'(1);
                    end else begin
                        fade_count_next = fc_a;
                    end
                    rem_next  = dvd_a[DVD_W-1:IDX_W];
                    dvd_next  = dvd_a[IDX_W-1:0];
                    cnt_next  = '0;
                    if (fading_a && (fade_samples_reg != '0)) begin
                        quot_next  = '0;
                        state_next = S_DIV;
                    end else begin
                        quot_next  = IDX_FULL;
                        state_next = S_RDS;
                    end
                end
            end
            S_DIV: begin
                rem_next  = div_ge ? FADE_W'(div_t - {1'b0, fade_samples_reg})
                                   : div_t[FADE_W-1:0];
                dvd_next  = {dvd_reg[IDX_W-2:0], 1'b0};
                quot_next = {quot_reg[IDX_W-2:0], div_ge};
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'(IDX_W - 1)) begin
                    state_next = S_RDS;
                end
            end
            S_RDS: begin
                state_next = S_RDC;
            end
            S_RDC: begin
                prod_next  = sample_reg * $signed({1'b0, rom_q_reg});
                state_next = S_MLC;
            end
            S_MLC: begin
                prod_next  = sample_reg * $signed({1'b0, rom_q_reg});
                nv_next    = scaled;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, out_ov, out_oc, out_nv, cur_ch_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // register writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FADE_SAMPLES: begin
                    fade_samples_next = cfg_wr_data[FADE_W-1:0];
                    fade_count_next   = '0;
                end
                REG_NUM_CHANNELS: begin
                    num_channels_next = cfg_wr_data[CH_W-1:0];
                end
                default: begin
                    num_channels_next = num_channels_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            fade_samples_reg <= FADE_SAMPLES_RST;
            num_channels_reg <= NUM_CHANNELS_RST;
            cur_ch_reg       <= '0;
            prev_ch_reg      <= '0;
            fade_count_reg   <= '0;
            cnt_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fade_samples_reg <= fade_samples_next;
            num_channels_reg <= num_channels_next;
            cur_ch_reg       <= cur_ch_next;
            prev_ch_reg      <= prev_ch_next;
            fade_count_reg   <= fade_count_next;
            cnt_reg          <= cnt_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // datapath registers and gain table read
    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        fading_reg  <= fading_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quot_reg    <= quot_next;
        prod_reg    <= prod_next;
        nv_reg      <= nv_next;
        m_tdata_reg <= m_tdata_next;
        rom_q_reg   <= GAIN_TAB[rom_addr];
    end

endmodule

### design/cfcg_checker.sv
// ----------------------------------------------------------------------------
// cfcg_checker
// Port-level checks for the crossfading channel gate, bound to crossfading_channel_gate_unit.
// ----------------------------------------------------------------------------
module cfcg_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [cfcg_pkg::M_DATA_W-1:0]        m_tdata
);
    import cfcg_pkg::*;

    logic [CH_W-1:0]     new_ch;
    logic [CH_W-1:0]     old_ch;
    logic [SAMPLE_W-1:0] old_val;

    assign new_ch  = m_tdata[CH_W-1:0];
    assign old_ch  = m_tdata[2*CH_W+SAMPLE_W-1:CH_W+SAMPLE_W];
    assign old_val = m_tdata[2*CH_W+2*SAMPLE_W-1:2*CH_W+SAMPLE_W];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one sample at a time: busy right after a word is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the current word finished");

    // the fading-out channel is never the fading-in one
    a_old_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (old_ch != '0) |-> (old_ch != new_ch))
        else $error("old and new channel coincide");

    // no channel fading out means no fade-out value
    a_old_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (old_ch == '0) |-> (old_val == '0))
        else $error("fade-out value without a channel");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind crossfading_channel_gate_unit cfcg_checker u_cfcg_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the crossfading channel gate. A bit-true tracker of
// the channel state and the quarter-sine gains predicts every output word; the
// stimulus walks through several fade lengths and channel counts with bursty
// input and a stalling output side, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          TABLE_STEPS = 1024;
    localparam int unsigned CH_LIMIT    = 256;
    localparam int unsigned UNITY_GAIN  = 65536;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PAD_W = cfcg_pkg::S_DATA_W - cfcg_pkg::CH_W - cfcg_pkg::SAMPLE_W;

    typedef struct {
        logic [8:0]  new_ch;
        logic [23:0] new_val;
        logic [8:0]  old_ch;
        logic [23:0] old_val;
    } route_word_t;

    // channel state, gains and the words still owed by the block
    class crossfade_tracker;
        logic [16:0] gain_q16 [TABLE_STEPS+1];
        logic [23:0] fade_len;
        logic [8:0]  chan_count;
        logic [8:0]  cur_ch;
        logic [8:0]  prev_ch;
        int          fade_pos;
        route_word_t due_words [$];
        int          errors;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned g;
            longint          sum;
            // quarter sine by a seven-term taylor series in q30, rounded to q1.16
            for (int k = 0; k <= TABLE_STEPS; k++) begin
                x    = (HALF_PI_Q30 * 64'(k) + 64'd512) / 64'd1024;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 6; n++) begin
                    term = (term * x2) >> 30;
                    term = term / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                g = (unsigned'(sum) + 64'd8192) >> 14;
                if (g > UNITY_GAIN) begin
                    g = UNITY_GAIN;
                end
                gain_q16[k] = g[16:0];
            end
            fade_len   = 24'd2400;
            chan_count = 9'd2;
            cur_ch     = '0;
            prev_ch    = '0;
            fade_pos   = 0;
            errors     = 0;
        endfunction

        // sample times q1.16 gain, halves rounded up
        function logic [23:0] apply_gain(logic signed [23:0] smp, logic [16:0] gain);
            longint prod;
            prod = longint'(smp) * longint'({1'b0, gain});
            prod = (prod + 64'sd32768) >>> 16;
            return prod[23:0];
        endfunction

        function void apply_config(logic [cfcg_pkg::CFG_ADDR_W-1:0] addr,
                                   logic [23:0] value);
            if (addr == cfcg_pkg::REG_FADE_SAMPLES) begin
                fade_len = value;
                fade_pos = 0;
            end else if (addr == cfcg_pkg::REG_NUM_CHANNELS) begin
                chan_count = value[8:0];
            end
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // advance the channel state by one accepted word and queue its result
        function void take_sample(logic [8:0] sel, logic [23:0] smp);
            int unsigned lim;
            logic [16:0] gs;
            logic [16:0] gc;
            longint      num;
            int          idx;
            bit          fading;
            route_word_t w;
            lim = (chan_count > CH_LIMIT) ? CH_LIMIT : chan_count;
            if (sel != cur_ch && sel <= lim) begin
                prev_ch  = cur_ch;
                cur_ch   = sel;
                fade_pos = int'(fade_len);
            end
            fading = (fade_pos >= 0);
            gs = 17'(UNITY_GAIN);
            gc = '0;
            if (fading) begin
                idx = TABLE_STEPS;
                if (fade_len != 0) begin
                    num = (fade_pos > fade_len) ? 0 : longint'(fade_len) - fade_pos;
                    num = (num * TABLE_STEPS + longint'(fade_len) / 2) / longint'(fade_len);
                    idx = (num > TABLE_STEPS) ? TABLE_STEPS : int'(num);
                end
                gs = gain_q16[idx];
                gc = gain_q16[TABLE_STEPS - idx];
            end
            w.new_ch  = '0;
            w.new_val = '0;
            w.old_ch  = '0;
            w.old_val = '0;
            if (cur_ch != 0) begin
                w.new_ch  = cur_ch;
                w.new_val = fading ? apply_gain(smp, gs) : smp;
            end
            if (prev_ch != 0 && fading) begin
                w.old_ch  = prev_ch;
                w.old_val = apply_gain(smp, gc);
            end
            // count held while the gate is fully off
            if (fading && (cur_ch != 0 || prev_ch != 0)) begin
                fade_pos--;
            end
            due_words.push_back(w);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_word(logic [cfcg_pkg::M_DATA_W-1:0] data);
            route_word_t w;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word %h", data));
                return;
            end
            w = due_words.pop_front();
            if (data[8:0] !== w.new_ch)
                report($sformatf("new_channel %0d, want %0d", data[8:0], w.new_ch));
            if (data[32:9] !== w.new_val)
                report($sformatf("new_value %h, want %h", data[32:9], w.new_val));
            if (data[41:33] !== w.old_ch)
                report($sformatf("old_channel %0d, want %0d", data[41:33], w.old_ch));
            if (data[65:42] !== w.old_val)
                report($sformatf("old_value %h, want %h", data[65:42], w.old_val));
        endtask
    endclass

    logic                                 aclk;
    logic                                 aresetn;
    // s_tdata: channel_select, sample_in, zero pad
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [cfcg_pkg::S_DATA_W-1:0]        s_tdata;
    // m_tdata: new_channel, new_value, old_channel, old_value, zero pad
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [cfcg_pkg::M_DATA_W-1:0]        m_tdata;
    logic                                 cfg_wr_en;
    logic [cfcg_pkg::CFG_ADDR_W-1:0]      cfg_addr;
    logic [cfcg_pkg::CFG_DATA_W-1:0]      cfg_wr_data;

    crossfade_tracker tracker = new();
    int               burst_left;
    bit               long_hold_req;
    int               cycle_count;

    int unsigned fade_plan [9] = '{1, 7, 16, 33, 2, 0, 64, 5, 12};
    int unsigned chan_plan [9] = '{2, 5, 256, 17, 511, 3, 100, 256, 9};

    crossfading_channel_gate_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_word(m_tdata);
        end
    end

    // output side: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int tick;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= tick[2];
                endcase
            end
        end
    end

    // offer one word; bursts of random length with random gaps between them
    task send_word(logic [8:0] sel, logic [23:0] smp);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, smp, sel};
        do @(posedge aclk); while (!s_tready);
        tracker.take_sample(sel, smp);
    endtask

    task stop_sending();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
    endtask

    task wait_drained();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_reg(logic [cfcg_pkg::CFG_ADDR_W-1:0] addr, logic [23:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.apply_config(addr, value);
    endtask

    // runs on one channel with random content, some gate-off and stray selects
    task run_random(int unsigned fade, int unsigned lim, int n_items);
        int          sent;
        int          run;
        int          r;
        logic [8:0]  target;
        logic [8:0]  sel;
        logic [23:0] smp;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                target = '0;
                run    = $urandom_range(1, fade + 4);
            end else if (r < 18) begin
                target = 9'($urandom_range(lim + 1, 511));
                run    = $urandom_range(1, 2);
            end else begin
                target = 9'($urandom_range(1, lim));
                run    = $urandom_range(1, fade + 6);
            end
            for (int i = 0; i < run && sent < n_items; i++) begin
                sel = ($urandom_range(0, 31) == 0) ? 9'($urandom_range(0, 511)) : target;
                case ($urandom_range(0, 19))
                    0:       smp = 24'h800000;
                    1:       smp = 24'h7FFFFF;
                    2:       smp = 24'h000000;
                    3:       smp = 24'hFFFFFF;
                    default: smp = 24'($urandom);
                endcase
                send_word(sel, smp);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned lim;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = cfcg_pkg::REG_FADE_SAMPLES;
        cfg_wr_data   = '0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        cycle_count   = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default settings: gate off, start of a long fade, stray selects, fade to off
        send_word(9'd0,   24'h7FFFFF);
        send_word(9'd1,   24'h7FFFFF);
        send_word(9'd1,   24'h800000);
        send_word(9'd3,   24'd100);
        send_word(9'd511, 24'hFFFFFF);
        send_word(9'd2,   24'h000000);
        send_word(9'd2,   24'd12345);
        send_word(9'd0,   24'h800000);
        stop_sending();
        wait_drained();

        // zero fade length switches at once; oversized count acts as the maximum
        write_reg(cfcg_pkg::REG_FADE_SAMPLES, 24'd0);
        write_reg(cfcg_pkg::REG_NUM_CHANNELS, 24'd511);
        send_word(9'd256, 24'h7FFFFF);
        send_word(9'd257, 24'd5);
        send_word(9'd0,   24'h800000);
        send_word(9'd1,   24'hFFFFFF);
        send_word(9'd255, 24'd1234);
        stop_sending();
        wait_drained();

        // count shrunk below the stored channel
        write_reg(cfcg_pkg::REG_NUM_CHANNELS, 24'd2);
        send_word(9'd255, 24'd7);
        send_word(9'd200, 24'd8);
        send_word(9'd2,   24'h800000);
        stop_sending();
        wait_drained();

        // short fade run to the end, then a fade cut short by a length write
        write_reg(cfcg_pkg::REG_FADE_SAMPLES, 24'd3);
        repeat (5) send_word(9'd1, 24'h7FFFFF);
        send_word(9'd2, 24'h800000);
        send_word(9'd2, 24'd4096);
        stop_sending();
        wait_drained();
        write_reg(cfcg_pkg::REG_FADE_SAMPLES, 24'hFFFFFF);
        send_word(9'd2, 24'd77);
        send_word(9'd2, -24'sd77);
        stop_sending();
        wait_drained();

        // random phases over a spread of fade lengths and channel counts
        for (int p = 0; p < 9; p++) begin
            write_reg(cfcg_pkg::REG_FADE_SAMPLES, 24'(fade_plan[p]));
            write_reg(cfcg_pkg::REG_NUM_CHANNELS, 24'(chan_plan[p]));
            lim = (chan_plan[p] > CH_LIMIT) ? CH_LIMIT : chan_plan[p];
            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            run_random(fade_plan[p], lim, 100);
            stop_sending();
            wait_drained();
        end

        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
design/cfcg_pkg.sv
design/crossfading_channel_gate_unit.sv
design/cfcg_checker.sv
tb/tb_top.sv
